// File: hdl/melp_pkg.sv
package melp_pkg;

   // Marker window: the date bytes are held back this far so "remote from" can be dropped
   localparam int MARK_LEN = 11;
   localparam int WIN_LEN  = MARK_LEN - 1;
   localparam int WIN_IDX_W = $clog2(WIN_LEN);
   localparam int FILL_W    = $clog2(WIN_LEN + 1);

   localparam logic [8*MARK_LEN-1:0] MARK_TEXT = "remote from";

   localparam logic [7:0] CHAR_ESCAPE = 8'h3E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   // Default depth of the op queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATE_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REMOTE_LIMIT  = 2'd2;

   localparam logic [7:0] ADDRESS_LIMIT_RST = 8'd127;
   localparam logic [7:0] DATE_LIMIT_RST    = 8'd63;
   localparam logic [7:0] REMOTE_LIMIT_RST  = 8'd63;

   typedef enum logic [3:0] {
      PH_HDR,
      PH_SKIP_A,
      PH_ADDR,
      PH_SKIP_D,
      PH_DATE,
      PH_SKIP_R,
      PH_REM,
      PH_DONE,
      PH_REJECT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ADDR   = 2'd0,
      KIND_DATE   = 2'd1,
      KIND_REMOTE = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] address_limit;
      logic [7:0] date_limit;
      logic [7:0] remote_limit;
   } limits_type;

   typedef logic [WIN_LEN-1:0][7:0] window_type;

   // One queue entry: an optional field byte, then a window flush, then a status item
   typedef struct packed {
      logic              byte_vld;
      kind_type          kind;
      logic [7:0]        field_byte;
      logic [FILL_W-1:0] flush_cnt;
      window_type        window;
      logic              status_vld;
      logic              is_envelope;
      logic              escaped;
   } op_type;

   function automatic logic is_white(input logic [7:0] b);
      is_white = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
                 (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
   endfunction

   // Characters of "From" by position
   function automatic logic [7:0] head_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h46;
         3'd1:    c = 8'h72;
         3'd2:    c = 8'h6F;
         3'd3:    c = 8'h6D;
         default: c = 8'h00;
      endcase
      head_char = c;
   endfunction

endpackage

// File: hdl/melp_stream_if.sv
interface melp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       line_end;

   modport source (output valid, output line_byte, output line_end, input ready);
   modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface melp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] field_byte;
   logic       is_envelope;
   logic       escaped;
   logic       run_end;

   modport source (output valid, output kind, output field_byte, output is_envelope,
                   output escaped, output run_end, input ready);
   modport sink   (input valid, input kind, input field_byte, input is_envelope,
                   input escaped, input run_end, output ready);
endinterface

// File: hdl/melp_front.sv
module melp_front (
   input  logic                clock,
   input  logic                reset,
   melp_req_if.sink            req_if,
   input  melp_pkg::limits_type limits,
   input  logic                q_full,
   output logic                q_push,
   output melp_pkg::op_type    q_op
);

   localparam logic [melp_pkg::FILL_W-1:0] WIN_FULL = melp_pkg::FILL_W'(melp_pkg::WIN_LEN);

   melp_pkg::phase_type              phase_ff, phase_in;
   logic [2:0]                       hpos_ff, hpos_in;
   logic                             esc_ff, esc_in;
   melp_pkg::window_type             win_ff, win_in;
   logic [melp_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [7:0]                       cnt_ff, cnt_in;

   logic                             accept;
   logic [7:0]                       b;
   logic                             do_flush;
   logic [8*melp_pkg::MARK_LEN-1:0]  cand;
   logic [7:0]                       rem;
   logic [7:0]                       fill_ext;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !q_full;
   assign b            = req_if.line_byte;

   // Full marker candidate: held window bytes then the incoming byte
   always_comb begin
      for (int i = 0; i < melp_pkg::WIN_LEN; i++) begin
         cand[8*(melp_pkg::MARK_LEN-1-i) +: 8] = win_ff[i];
      end
      cand[7:0] = b;
   end

   // Classify the request and build the op for the back end
   always_comb begin
      phase_in = phase_ff;
      hpos_in  = hpos_ff;
      esc_in   = esc_ff;
      win_in   = win_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      do_flush = 1'b0;
      rem      = 8'd0;
      fill_ext = 8'd0;
      q_op     = '0;
      q_op.window = win_ff;

      if (accept) begin
         case (phase_ff)
            melp_pkg::PH_HDR: begin
               if (hpos_ff == 3'd0 && !esc_ff && b == melp_pkg::CHAR_ESCAPE) begin
                  esc_in = 1'b1;
               end else if (hpos_ff < 3'd4) begin
                  if (b == melp_pkg::head_char(hpos_ff)) hpos_in = hpos_ff + 3'd1;
                  else phase_in = melp_pkg::PH_REJECT;
               end else begin
                  phase_in = (b == melp_pkg::CHAR_SPACE || b == melp_pkg::CHAR_TAB) ?
                             melp_pkg::PH_SKIP_A : melp_pkg::PH_REJECT;
               end
            end
            melp_pkg::PH_SKIP_A: begin
               if (b == melp_pkg::CHAR_NUL) begin
                  phase_in = melp_pkg::PH_DONE;
               end else if (!melp_pkg::is_white(b)) begin
                  cnt_in = 8'd0;
                  if (limits.address_limit != 8'd0) begin
                     q_op.byte_vld = 1'b1;
                     cnt_in = 8'd1;
                  end
                  q_op.kind = melp_pkg::KIND_ADDR;
                  q_op.field_byte = b;
                  phase_in = melp_pkg::PH_ADDR;
               end
            end
            melp_pkg::PH_ADDR: begin
               if (b == melp_pkg::CHAR_NUL) begin
                  phase_in = melp_pkg::PH_DONE;
               end else if (melp_pkg::is_white(b)) begin
                  phase_in = melp_pkg::PH_SKIP_D;
               end else if (cnt_ff < limits.address_limit) begin
                  q_op.byte_vld = 1'b1;
                  q_op.kind = melp_pkg::KIND_ADDR;
                  q_op.field_byte = b;
                  cnt_in = cnt_ff + 8'd1;
               end
            end
            melp_pkg::PH_SKIP_D: begin
               if (b == melp_pkg::CHAR_NUL) begin
                  phase_in = melp_pkg::PH_DONE;
               end else if (!melp_pkg::is_white(b)) begin
                  cnt_in    = 8'd0;
                  win_in[0] = b;
                  fill_in   = melp_pkg::FILL_W'(1);
                  phase_in  = melp_pkg::PH_DATE;
               end
            end
            melp_pkg::PH_DATE: begin
               if (b == melp_pkg::CHAR_NUL) begin
                  do_flush = 1'b1;
                  phase_in = melp_pkg::PH_DONE;
               end else if (fill_ff < WIN_FULL) begin
                  win_in[fill_ff[melp_pkg::WIN_IDX_W-1:0]] = b;
                  fill_in = fill_ff + melp_pkg::FILL_W'(1);
               end else if (cand == melp_pkg::MARK_TEXT) begin
                  // marker matched: the held bytes are the marker itself
                  fill_in  = '0;
                  phase_in = melp_pkg::PH_SKIP_R;
               end else begin
                  // oldest byte leaves the window
                  if (cnt_ff < limits.date_limit) begin
                     q_op.byte_vld = 1'b1;
                     cnt_in = cnt_ff + 8'd1;
                  end
                  q_op.kind = melp_pkg::KIND_DATE;
                  q_op.field_byte = win_ff[0];
                  for (int i = 0; i < melp_pkg::WIN_LEN - 1; i++) begin
                     win_in[i] = win_ff[i+1];
                  end
                  win_in[melp_pkg::WIN_LEN-1] = b;
               end
            end
            melp_pkg::PH_SKIP_R: begin
               if (b == melp_pkg::CHAR_NUL) begin
                  phase_in = melp_pkg::PH_DONE;
               end else if (!melp_pkg::is_white(b)) begin
                  cnt_in = 8'd0;
                  if (limits.remote_limit != 8'd0) begin
                     q_op.byte_vld = 1'b1;
                     cnt_in = 8'd1;
                  end
                  q_op.kind = melp_pkg::KIND_REMOTE;
                  q_op.field_byte = b;
                  phase_in = melp_pkg::PH_REM;
               end
            end
            melp_pkg::PH_REM: begin
               if (b == melp_pkg::CHAR_NUL || melp_pkg::is_white(b)) begin
                  phase_in = melp_pkg::PH_DONE;
               end else if (cnt_ff < limits.remote_limit) begin
                  q_op.byte_vld = 1'b1;
                  q_op.kind = melp_pkg::KIND_REMOTE;
                  q_op.field_byte = b;
                  cnt_in = cnt_ff + 8'd1;
               end
            end
            default: begin
            end
         endcase

         // End of line: flush held date bytes, then status
         if (req_if.line_end) begin
            if (phase_in == melp_pkg::PH_DATE) do_flush = 1'b1;
            q_op.status_vld  = 1'b1;
            q_op.is_envelope = (phase_in != melp_pkg::PH_HDR) &&
                               (phase_in != melp_pkg::PH_REJECT);
            q_op.escaped     = esc_in;
         end

         // Flush length is bounded by what the date limit still allows
         if (do_flush && cnt_in < limits.date_limit) begin
            rem = limits.date_limit - cnt_in;
            fill_ext = {{(8-melp_pkg::FILL_W){1'b0}}, fill_in};
            q_op.flush_cnt = (rem < fill_ext) ? rem[melp_pkg::FILL_W-1:0] : fill_in;
         end
         q_op.window = win_in;

         if (req_if.line_end) begin
            phase_in = melp_pkg::PH_HDR;
            hpos_in  = 3'd0;
            esc_in   = 1'b0;
            fill_in  = '0;
            cnt_in   = 8'd0;
         end
      end
   end

   assign q_push = accept && (q_op.byte_vld || q_op.status_vld || (q_op.flush_cnt != '0));

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= melp_pkg::PH_HDR;
         hpos_ff  <= 3'd0;
         esc_ff   <= 1'b0;
         fill_ff  <= '0;
         cnt_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         hpos_ff  <= hpos_in;
         esc_ff   <= esc_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Window bytes
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// File: hdl/melp_queue.sv
module melp_queue #(
   parameter int DEPTH = melp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  melp_pkg::op_type push_op,
   input  logic             pop,
   output melp_pkg::op_type head_op,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   melp_pkg::op_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_FULL);
   assign head_op = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (!push && pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_op;
   end

endmodule

// File: hdl/melp_back.sv
module melp_back (
   input  logic             clock,
   input  logic             reset,
   input  melp_pkg::op_type head_op,
   input  logic             q_empty,
   output logic             q_pop,
   melp_rsp_if.source       rsp_if
);

   logic                         byte_done_ff, byte_done_in;
   logic [melp_pkg::FILL_W-1:0]  fidx_ff, fidx_in;

   logic                         vld_ff, vld_in;
   melp_pkg::kind_type           kind_ff, kind_in;
   logic [7:0]                   field_ff, field_in;
   logic                         env_ff, env_in;
   logic                         esc_ff, esc_in;
   logic                         end_ff, end_in;

   logic                         slot_free;
   logic                         issue;
   logic                         item_last;

   assign slot_free = !vld_ff || rsp_if.ready;
   assign issue     = !q_empty && slot_free;
   assign q_pop     = issue && item_last;

   // Pick the next result item of the head op
   always_comb begin
      kind_in  = kind_ff;
      field_in = field_ff;
      env_in   = env_ff;
      esc_in   = esc_ff;
      end_in   = end_ff;
      item_last    = 1'b1;
      byte_done_in = byte_done_ff;
      fidx_in      = fidx_ff;

      if (head_op.byte_vld && !byte_done_ff) begin
         kind_in   = head_op.kind;
         field_in  = head_op.field_byte;
         env_in    = 1'b0;
         esc_in    = 1'b0;
         end_in    = 1'b0;
         item_last = (head_op.flush_cnt == '0) && !head_op.status_vld;
      end else if (fidx_ff < head_op.flush_cnt) begin
         kind_in   = melp_pkg::KIND_DATE;
         field_in  = head_op.window[fidx_ff[melp_pkg::WIN_IDX_W-1:0]];
         env_in    = 1'b0;
         esc_in    = 1'b0;
         end_in    = 1'b0;
         item_last = ((fidx_ff + melp_pkg::FILL_W'(1)) == head_op.flush_cnt) &&
                     !head_op.status_vld;
      end else begin
         kind_in   = melp_pkg::KIND_STATUS;
         field_in  = 8'd0;
         env_in    = head_op.is_envelope;
         esc_in    = head_op.escaped;
         end_in    = 1'b1;
      end

      if (issue) begin
         if (item_last) begin
            byte_done_in = 1'b0;
            fidx_in      = '0;
         end else if (head_op.byte_vld && !byte_done_ff) begin
            byte_done_in = 1'b1;
         end else begin
            fidx_in = fidx_ff + melp_pkg::FILL_W'(1);
         end
      end
   end

   assign vld_in = issue ? 1'b1 : (rsp_if.ready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_done_ff <= 1'b0;
         fidx_ff      <= '0;
         vld_ff       <= 1'b0;
      end else begin
         byte_done_ff <= byte_done_in;
         fidx_ff      <= fidx_in;
         vld_ff       <= vld_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (issue) begin
         kind_ff  <= kind_in;
         field_ff <= field_in;
         env_ff   <= env_in;
         esc_ff   <= esc_in;
         end_ff   <= end_in;
      end
   end

   assign rsp_if.valid       = vld_ff;
   assign rsp_if.kind        = kind_ff;
   assign rsp_if.field_byte  = field_ff;
   assign rsp_if.is_envelope = env_ff;
   assign rsp_if.escaped     = esc_ff;
   assign rsp_if.run_end     = end_ff;

`ifndef SYNTHESIS
   // Status item and line end always travel together
   a_status_is_end: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (end_ff == (kind_ff == melp_pkg::KIND_STATUS)))
      else $error("status kind and run_end disagree");

   // Flush index never runs past the head's flush length
   a_fidx_bound: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (fidx_ff <= head_op.flush_cnt))
      else $error("flush index beyond flush length");

   // After a pop the per-op progress is cleared
   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (!byte_done_ff && fidx_ff == '0))
      else $error("op progress not cleared after pop");
`endif

endmodule

// File: hdl/mbox_envelope_line_parser_unit.sv
// The first result of a request passes through the op queue and then the output register.
// Throughput: one request per cycle while results keep pace; a request that ends a line
// or a date field emits up to 12 results; the back end drains them one per cycle, while
// results are taken, from a QUEUE_DEPTH-entry op queue; requests stall only when it is full.
// Reset: synchronous, active high; clears parser state, queue and output valid, and
// loads the field limits 127, 63, 63. No clearing pass.
module mbox_envelope_line_parser_unit #(
   parameter int QUEUE_DEPTH = melp_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   melp_req_if.sink                         req_if,
   melp_rsp_if.source                       rsp_if,
   input  logic                             csr_wr_en,
   input  logic [melp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);

   melp_pkg::limits_type limits_ff;
   melp_pkg::op_type     push_op;
   melp_pkg::op_type     head_op;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_empty;
   logic                 q_full;

   // Field limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.address_limit <= melp_pkg::ADDRESS_LIMIT_RST;
         limits_ff.date_limit    <= melp_pkg::DATE_LIMIT_RST;
         limits_ff.remote_limit  <= melp_pkg::REMOTE_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            melp_pkg::CSR_ADDRESS_LIMIT: limits_ff.address_limit <= csr_wdata;
            melp_pkg::CSR_DATE_LIMIT:    limits_ff.date_limit    <= csr_wdata;
            melp_pkg::CSR_REMOTE_LIMIT:  limits_ff.remote_limit  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   melp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .limits (limits_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_op   (push_op)
   );

   melp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .pop     (q_pop),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   melp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head_op (head_op),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

// File: tb/sv/melp_check_pkg.sv
package melp_check_pkg;
   import melp_pkg::*;

   // Header text that opens an envelope line, first character in the top byte
   localparam logic [31:0] HEAD_TEXT = "From";

   // One tagged output of the parser
   typedef struct {
      kind_type   kind;
      logic [7:0] field_byte;
      logic       is_envelope;
      logic       escaped;
      logic       run_end;
   } line_item_t;

   class env_line_scoreboard;
      logic [7:0] address_max;
      logic [7:0] date_max;
      logic [7:0] remote_max;

      // Parser state, cleared at the end of every line
      phase_type  parse_phase;
      logic [2:0] head_pos;
      logic       escape_seen;
      logic [7:0] date_window [MARK_LEN];
      int         window_fill;
      logic [7:0] field_count;

      line_item_t  expected_items [$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned lines_parsed;
      int unsigned envelope_lines;

      function new();
         address_max     = ADDRESS_LIMIT_RST;
         date_max        = DATE_LIMIT_RST;
         remote_max      = REMOTE_LIMIT_RST;
         mismatches      = 0;
         results_checked = 0;
         lines_parsed    = 0;
         envelope_lines  = 0;
         clear_line();
      endfunction

      static function bit is_blank(logic [7:0] b);
         return b inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
      endfunction

      function int pending();
         return expected_items.size();
      endfunction

      function void clear_line();
         parse_phase = PH_HDR;
         head_pos    = 3'd0;
         escape_seen = 1'b0;
         foreach (date_window[i]) date_window[i] = 8'h00;
         window_fill = 0;
         field_count = 8'd0;
      endfunction

      function void push_item(kind_type k, logic [7:0] b, logic env, logic esc, logic last);
         line_item_t item;
         item.kind        = k;
         item.field_byte  = b;
         item.is_envelope = env;
         item.escaped     = esc;
         item.run_end     = last;
         expected_items.push_back(item);
      endfunction

      // Field byte, dropped once the field has reached its limit
      function void push_field(kind_type k, logic [7:0] b, logic [7:0] lim);
         if (field_count < lim) begin
            field_count++;
            push_item(k, b, 1'b0, 1'b0, 1'b0);
         end
      endfunction

      function void flush_date();
         for (int i = 0; i < window_fill; i++) push_field(KIND_DATE, date_window[i], date_max);
         window_fill = 0;
      endfunction

      // Advance the parser by one accepted request
      function void note_request(logic [7:0] b, logic last);
         bit   hit;
         logic env;
         case (parse_phase)
            PH_HDR: begin
               if (head_pos == 3'd0 && !escape_seen && b == CHAR_ESCAPE) begin
                  escape_seen = 1'b1;
               end else if (head_pos < 3'd4) begin
                  if (b == HEAD_TEXT[8*(3-head_pos) +: 8]) head_pos++;
                  else parse_phase = PH_REJECT;
               end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
                  parse_phase = PH_SKIP_A;
               end else begin
                  parse_phase = PH_REJECT;
               end
            end
            PH_SKIP_A: begin
               if (b == CHAR_NUL) begin
                  parse_phase = PH_DONE;
               end else if (!is_blank(b)) begin
                  field_count = 8'd0;
                  push_field(KIND_ADDR, b, address_max);
                  parse_phase = PH_ADDR;
               end
            end
            PH_ADDR: begin
               if (b == CHAR_NUL) parse_phase = PH_DONE;
               else if (is_blank(b)) parse_phase = PH_SKIP_D;
               else push_field(KIND_ADDR, b, address_max);
            end
            PH_SKIP_D: begin
               if (b == CHAR_NUL) begin
                  parse_phase = PH_DONE;
               end else if (!is_blank(b)) begin
                  field_count    = 8'd0;
                  date_window[0] = b;
                  window_fill    = 1;
                  parse_phase    = PH_DATE;
               end
            end
            PH_DATE: begin
               if (b == CHAR_NUL) begin
                  flush_date();
                  parse_phase = PH_DONE;
               end else begin
                  date_window[window_fill] = b;
                  window_fill++;
                  // Full window: either the marker, or the oldest byte leaves as date
                  if (window_fill == MARK_LEN) begin
                     hit = 1'b1;
                     for (int i = 0; i < MARK_LEN; i++)
                        if (date_window[i] != MARK_TEXT[8*(MARK_LEN-1-i) +: 8]) hit = 1'b0;
                     if (hit) begin
                        window_fill = 0;
                        parse_phase = PH_SKIP_R;
                     end else begin
                        push_field(KIND_DATE, date_window[0], date_max);
                        for (int i = 0; i < MARK_LEN - 1; i++) date_window[i] = date_window[i+1];
                        window_fill = MARK_LEN - 1;
                     end
                  end
               end
            end
            PH_SKIP_R: begin
               if (b == CHAR_NUL) begin
                  parse_phase = PH_DONE;
               end else if (!is_blank(b)) begin
                  field_count = 8'd0;
                  push_field(KIND_REMOTE, b, remote_max);
                  parse_phase = PH_REM;
               end
            end
            PH_REM: begin
               if (b == CHAR_NUL || is_blank(b)) parse_phase = PH_DONE;
               else push_field(KIND_REMOTE, b, remote_max);
            end
            default: ;
         endcase

         // End of line: drain held date bytes, then the status
         if (last) begin
            if (parse_phase == PH_DATE) flush_date();
            env = (parse_phase != PH_HDR && parse_phase != PH_REJECT);
            push_item(KIND_STATUS, 8'h00, env, escape_seen, 1'b1);
            lines_parsed++;
            if (env) envelope_lines++;
            clear_line();
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] fbyte, logic env, logic esc,
                                 logic last);
         line_item_t want;
         results_checked++;
         if (expected_items.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                     $time, kind, fbyte);
            return;
         end
         want = expected_items.pop_front();
         compare_field("kind", want.kind, kind);
         compare_field("field_byte", want.field_byte, fbyte);
         compare_field("is_envelope", want.is_envelope, env);
         compare_field("escaped", want.escaped, esc);
         compare_field("run_end", want.run_end, last);
      endfunction
   endclass

endpackage

// File: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import melp_pkg::*;
   import melp_check_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 60;
   localparam int BYTES_PER_LIMITS = 48;
   localparam int LIMIT_SETTINGS   = 7;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   melp_req_if req_bus ();
   melp_rsp_if rsp_bus ();

   env_line_scoreboard line_check;
   logic [7:0]         line_buf [$];
   bit                 stall_enable = 1'b1;
   int unsigned        quiet_cycles;
   int unsigned        bytes_sent;

   mbox_envelope_line_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            line_check.note_request(req_bus.line_byte, req_bus.line_end);
         if (rsp_bus.valid && rsp_bus.ready)
            line_check.check_result(rsp_bus.kind, rsp_bus.field_byte, rsp_bus.is_envelope,
                                    rsp_bus.escaped, rsp_bus.run_end);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Result side back-pressure in random bursts
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (stall_enable && $urandom_range(0, 1) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (stall_enable && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.line_byte <= b;
      req_bus.line_end  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   // Mostly space, otherwise tab through carriage return
   function automatic logic [7:0] blank_char();
      if ($urandom_range(0, 2) != 0) return CHAR_SPACE;
      return 8'h09 + 8'($urandom_range(0, 4));
   endfunction

   // Any non-zero, non-blank byte, biased toward printable text
   function automatic logic [7:0] token_char();
      logic [7:0] c;
      do
         c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h21, 8'h7E))
                                         : 8'($urandom_range(1, 255));
      while (env_line_scoreboard::is_blank(c));
      return c;
   endfunction

   function automatic void add_token(int unsigned len);
      repeat (len) line_buf.push_back(token_char());
   endfunction

   // Well-formed envelope line with random fields, sometimes cut short or broken by a zero
   function automatic void build_envelope_line();
      int unsigned cut;
      if ($urandom_range(0, 3) == 0) line_buf.push_back(CHAR_ESCAPE);
      add_text("From");
      line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
      add_token($urandom_range(1, 8));
      repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
      // date words, some of them partial marker text
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 5))
            0:       add_text("remote");
            1:       add_text("remot");
            2:       add_text("from");
            default: add_token($urandom_range(1, 6));
         endcase
         line_buf.push_back($urandom_range(0, 3) != 0 ? CHAR_SPACE : blank_char());
      end
      if ($urandom_range(0, 2) != 0) begin
         add_text("remote from");
         repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
         add_token($urandom_range(1, 8));
         if ($urandom_range(0, 1) == 1) begin
            line_buf.push_back(blank_char());
            add_token($urandom_range(1, 4));
         end
      end else begin
         add_token($urandom_range(1, 5));
      end
      case ($urandom_range(0, 7))
         0: begin
            cut = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > cut) void'(line_buf.pop_back());
         end
         1: begin
            line_buf.insert($urandom_range(0, line_buf.size()), CHAR_NUL);
            add_token($urandom_range(0, 3));
         end
         default: ;
      endcase
   endfunction

   // Lines that fail the header check
   function automatic void build_noise_line();
      case ($urandom_range(0, 4))
         0: repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
         1: add_text(">>From x");
         2: begin
            if ($urandom_range(0, 1) == 1) add_text("from a");
            else add_text("FROM b");
         end
         3: begin
            add_text("From");
            add_token($urandom_range(1, 5));
         end
         default: begin
            line_buf.push_back(CHAR_ESCAPE);
            repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   // Stop requests and let every outstanding result drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (line_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input logic [7:0] addr_lim, input logic [7:0] date_lim,
                               input logic [7:0] rem_lim);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ADDRESS_LIMIT;
      csr_wdata <= addr_lim;
      @(posedge clock);
      csr_index <= CSR_DATE_LIMIT;
      csr_wdata <= date_lim;
      @(posedge clock);
      csr_index <= CSR_REMOTE_LIMIT;
      csr_wdata <= rem_lim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      line_check.address_max = addr_lim;
      line_check.date_max    = date_lim;
      line_check.remote_max  = rem_lim;
   endtask

   initial begin
      int unsigned stretch_start;
      line_check        = new();
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_ADDRESS_LIMIT;
      csr_wdata         = 8'h00;
      req_bus.valid     = 1'b0;
      req_bus.line_byte = 8'h00;
      req_bus.line_end  = 1'b0;
      bytes_sent        = 0;
      quiet_cycles      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed lines under the reset limits
      add_text("Fr");
      line_buf.push_back(CHAR_NUL);
      send_line();
      add_text(">>F");
      send_line();
      add_text(">From");
      send_line();
      line_buf.push_back(8'hFF);
      send_line();
      add_text("From\ta d remote from r x");
      send_line();

      // Random lines, one stretch per limit setting; the last runs without random stalls
      for (int k = 0; k < LIMIT_SETTINGS; k++) begin
         if (k > 0) begin
            wait_idle();
            case (k)
               1: write_limits(8'd0, 8'd0, 8'd0);
               2: write_limits(8'd255, 8'd255, 8'd255);
               3: write_limits(8'd3, 8'd5, 8'd2);
               4: write_limits(8'd1, 8'd255, 8'd0);
               5: write_limits(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                               8'($urandom_range(0, 12)));
               default: begin
                  stall_enable = 1'b0;
                  write_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
               end
            endcase
         end
         stretch_start = bytes_sent;
         while (bytes_sent - stretch_start < BYTES_PER_LIMITS) begin
            if ($urandom_range(0, 3) != 0) build_envelope_line();
            else build_noise_line();
            send_line();
         end
      end
      wait_idle();

      $display("Sent %0d line bytes in %0d lines (%0d envelope lines) over %0d limit settings.",
               bytes_sent, line_check.lines_parsed, line_check.envelope_lines, LIMIT_SETTINGS);
      $display("Compared %0d results, %0d mismatches.", line_check.results_checked,
               line_check.mismatches);
      if (line_check.mismatches == 0 && line_check.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: mbox_envelope_line_parser_unit.f
hdl/melp_pkg.sv
hdl/melp_stream_if.sv
hdl/melp_front.sv
hdl/melp_queue.sv
hdl/melp_back.sv
hdl/mbox_envelope_line_parser_unit.sv
tb/sv/melp_check_pkg.sv
tb/sv/tb_top.sv
